[rtl/core/mhk_pkg.sv]
// Shared types and codes for the max-heap key engine.
// Holds the operation and status codes and the request and result structures.
// Depends on nothing; every other file of the block refers to it by scoped names.
`default_nettype none

package mhk_pkg;

  localparam int unsigned KEY_W   = 32;
  localparam int unsigned SLOT_W  = 11;
  localparam int unsigned COUNT_W = 11;

  typedef enum logic [1:0] {
    OP_APPEND = 2'd0,
    OP_CHANGE = 2'd1,
    OP_REMOVE = 2'd2,
    OP_READ   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SLOT = 2'd1,
    ST_FULL     = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       operation;
    logic [SLOT_W-1:0]         slot;
    logic signed [KEY_W-1:0]   key_value;
  } req_t;

  typedef struct packed {
    status_t                   status;
    logic signed [KEY_W-1:0]   read_key;
    logic [COUNT_W-1:0]        heap_count;
    logic signed [KEY_W-1:0]   top_key;
  } res_t;

endpackage

`default_nettype wire

[rtl/core/mhk_store.sv]
// Key memory of the max-heap key engine: one write port, one registered read port.
// Uses mhk_pkg for the key width.
`default_nettype none

module mhk_store #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  wire logic                              clk,
  input  wire logic                              we,
  input  wire logic [AW-1:0]                     waddr,
  input  wire logic signed [mhk_pkg::KEY_W-1:0]  wdata,
  input  wire logic                              re,
  input  wire logic [AW-1:0]                     raddr,
  output logic signed [mhk_pkg::KEY_W-1:0]       rdata
);

  logic signed [mhk_pkg::KEY_W-1:0] mem [DEPTH];
  logic signed [mhk_pkg::KEY_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

[rtl/core/mhk_sift.sv]
// Operation sequencer of the max-heap key engine: decodes an item, walks the heap
// up and then down through the key memory, and presents the result. Uses mhk_pkg.
`default_nettype none

module mhk_sift #(
  parameter int unsigned HEAP_DEPTH = 1024,
  parameter int unsigned AW         = 10
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              req_valid,
  input  wire mhk_pkg::req_t                     req,
  output logic                                   req_ready,
  output logic                                   res_valid,
  output mhk_pkg::res_t                          res,
  input  wire logic                              res_take,
  output logic                                   mem_we,
  output logic [AW-1:0]                          mem_waddr,
  output logic signed [mhk_pkg::KEY_W-1:0]       mem_wdata,
  output logic                                   mem_re,
  output logic [AW-1:0]                          mem_raddr,
  input  wire logic signed [mhk_pkg::KEY_W-1:0]  mem_rdata
);

  localparam int unsigned SW = $clog2(HEAP_DEPTH + 1);
  localparam int unsigned CW = (SW > mhk_pkg::SLOT_W) ? SW : mhk_pkg::SLOT_W;

  typedef enum logic [8:0] {
    S_IDLE = 9'b000000001,
    S_RDW  = 9'b000000010,
    S_RMW  = 9'b000000100,
    S_UPS  = 9'b000001000,
    S_UPC  = 9'b000010000,
    S_DNL  = 9'b000100000,
    S_DNR  = 9'b001000000,
    S_DNC  = 9'b010000000,
    S_FIN  = 9'b100000000
  } state_t;

  state_t                           state_r, state_nxt;
  logic [SW-1:0]                    size_r, size_nxt;
  logic [SW-1:0]                    p_r, p_nxt;
  logic signed [mhk_pkg::KEY_W-1:0] key_r, key_nxt;
  logic signed [mhk_pkg::KEY_W-1:0] left_r, left_nxt;
  logic                             rok_r, rok_nxt;
  mhk_pkg::status_t                 status_r, status_nxt;
  logic signed [mhk_pkg::KEY_W-1:0] rkey_r, rkey_nxt;
  logic signed [mhk_pkg::KEY_W-1:0] top_r;

  logic [CW-1:0]                    slot_ext;
  logic [CW-1:0]                    size_ext;
  logic [SW-1:0]                    slot_pos;
  logic                             slot_ok;
  logic                             full;
  logic [SW-1:0]                    parent;
  logic [SW-1:0]                    grand;
  logic [SW:0]                      lpos;
  logic [SW:0]                      rpos;
  logic [SW:0]                      size_w;
  logic signed [mhk_pkg::KEY_W-1:0] best_key;
  logic [SW-1:0]                    best_pos;
  logic                             best_moved;

  function automatic logic [AW-1:0] pos_addr(input logic [SW-1:0] pos);
    logic [SW-1:0] d;
    d = pos - SW'(1);
    return d[AW-1:0];
  endfunction

  assign slot_ext = CW'(req.slot);
  assign size_ext = CW'(size_r);
  assign slot_ok  = (slot_ext != '0) && (slot_ext <= size_ext);
  assign slot_pos = slot_ext[SW-1:0];
  assign full     = (size_r == SW'(HEAP_DEPTH));
  assign parent   = p_r >> 1;
  assign grand    = p_r >> 2;
  assign lpos     = {p_r, 1'b0};
  assign rpos     = {p_r, 1'b1};
  assign size_w   = {1'b0, size_r};

  // Larger child wins only when strictly greater; ties go to the left child.
  always_comb begin
    best_key   = key_r;
    best_pos   = p_r;
    best_moved = 1'b0;
    if (left_r > key_r) begin
      best_key   = left_r;
      best_pos   = lpos[SW-1:0];
      best_moved = 1'b1;
    end
    if (rok_r && (mem_rdata > best_key)) begin
      best_key   = mem_rdata;
      best_pos   = rpos[SW-1:0];
      best_moved = 1'b1;
    end
  end

  always_comb begin
    state_nxt  = state_r;
    size_nxt   = size_r;
    p_nxt      = p_r;
    key_nxt    = key_r;
    left_nxt   = left_r;
    rok_nxt    = rok_r;
    status_nxt = status_r;
    rkey_nxt   = rkey_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = '0;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    case (state_r)
      S_IDLE: begin
        if (req_valid) begin
          status_nxt = mhk_pkg::ST_OK;
          rkey_nxt   = '0;
          state_nxt  = S_FIN;
          if (req.operation == mhk_pkg::OP_APPEND) begin
            if (full) begin
              status_nxt = mhk_pkg::ST_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = size_r[AW-1:0];
              mem_wdata = req.key_value;
              size_nxt  = size_r + SW'(1);
            end
          end else if (!slot_ok) begin
            status_nxt = mhk_pkg::ST_BAD_SLOT;
          end else begin
            case (req.operation)
              mhk_pkg::OP_CHANGE: begin
                key_nxt   = req.key_value;
                p_nxt     = slot_pos;
                state_nxt = S_UPS;
              end
              mhk_pkg::OP_REMOVE: begin
                p_nxt = slot_pos;
                if (slot_pos == size_r) begin
                  size_nxt = size_r - SW'(1);
                end else begin
                  mem_re    = 1'b1;
                  mem_raddr = pos_addr(size_r);
                  state_nxt = S_RMW;
                end
              end
              mhk_pkg::OP_READ: begin
                mem_re    = 1'b1;
                mem_raddr = pos_addr(slot_pos);
                state_nxt = S_RDW;
              end
              default: begin
                state_nxt = S_FIN;
              end
            endcase
          end
        end
      end
      S_RDW: begin
        rkey_nxt  = mem_rdata;
        state_nxt = S_FIN;
      end
      S_RMW: begin
        key_nxt   = mem_rdata;
        size_nxt  = size_r - SW'(1);
        state_nxt = S_UPS;
      end
      S_UPS: begin
        if (p_r == SW'(1)) begin
          state_nxt = S_DNL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_addr(parent);
          state_nxt = S_UPC;
        end
      end
      S_UPC: begin
        if (key_r > mem_rdata) begin
          mem_we    = 1'b1;
          mem_waddr = pos_addr(p_r);
          mem_wdata = mem_rdata;
          p_nxt     = parent;
          if (parent == SW'(1)) begin
            state_nxt = S_DNL;
          end else begin
            mem_re    = 1'b1;
            mem_raddr = pos_addr(grand);
          end
        end else begin
          state_nxt = S_DNL;
        end
      end
      S_DNL: begin
        if (lpos > size_w) begin
          mem_we    = 1'b1;
          mem_waddr = pos_addr(p_r);
          mem_wdata = key_r;
          state_nxt = S_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = pos_addr(lpos[SW-1:0]);
          state_nxt = S_DNR;
        end
      end
      S_DNR: begin
        left_nxt  = mem_rdata;
        rok_nxt   = (rpos <= size_w);
        state_nxt = S_DNC;
        if (rpos <= size_w) begin
          mem_re    = 1'b1;
          mem_raddr = pos_addr(rpos[SW-1:0]);
        end
      end
      S_DNC: begin
        mem_we    = 1'b1;
        mem_waddr = pos_addr(p_r);
        mem_wdata = best_key;
        if (best_moved) begin
          p_nxt     = best_pos;
          state_nxt = S_DNL;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_FIN: begin
        if (res_take) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      size_r  <= '0;
    end else begin
      state_r <= state_nxt;
      size_r  <= size_nxt;
    end
  end

  // Position one is mirrored in a register so the top key needs no read port.
  always_ff @(posedge clk) begin
    p_r      <= p_nxt;
    key_r    <= key_nxt;
    left_r   <= left_nxt;
    rok_r    <= rok_nxt;
    status_r <= status_nxt;
    rkey_r   <= rkey_nxt;
    if (mem_we && (mem_waddr == '0)) begin
      top_r <= mem_wdata;
    end
  end

  assign req_ready      = (state_r == S_IDLE);
  assign res_valid      = (state_r == S_FIN);
  assign res.status     = status_r;
  assign res.read_key   = rkey_r;
  assign res.heap_count = size_ext[mhk_pkg::COUNT_W-1:0];
  assign res.top_key    = (size_r == '0) ? '0 : top_r;

endmodule

`default_nettype wire

[rtl/core/max_heap_key_engine.sv]
// Top level of the max-heap key engine: ports, output register and key memory.
// Instantiates mhk_sift and mhk_store; uses mhk_pkg for types and codes.
//
//   channel  direction  handshake          payload
//   in       input      in_valid/in_stall  in_operation, in_slot, in_key_value
//   out      output     out_valid/out_stall out_status, out_read_key,
//                                          out_heap_count, out_top_key
//
// One item is worked at a time. Append and every rejected item go straight to the
// finish state; a read waits for its key from the memory. Change key and remove climb
// and then descend the heap level by level, since every child and parent key comes
// through the single read port of the key memory. Appended keys need not be in heap
// order, so a key can climb to the root and then descend the other side.
// Reset clears the heap count and the sequencer; the key memory is not cleared,
// as only addresses below the count are ever read. The output register holds a
// finished result while out_stall is high; a later result then waits in the
// sequencer, and no new item is taken meanwhile.
`default_nettype none

module max_heap_key_engine #(
  parameter int unsigned HEAP_DEPTH = 1024
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [1:0]                            in_operation,
  input  wire logic [mhk_pkg::SLOT_W-1:0]            in_slot,
  input  wire logic signed [mhk_pkg::KEY_W-1:0]      in_key_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [1:0]                                 out_status,
  output logic signed [mhk_pkg::KEY_W-1:0]           out_read_key,
  output logic [mhk_pkg::COUNT_W-1:0]                out_heap_count,
  output logic signed [mhk_pkg::KEY_W-1:0]           out_top_key
);

  // Memory address width; at least one bit even for the smallest heap.
  localparam int unsigned AW = (HEAP_DEPTH > 1) ? $clog2(HEAP_DEPTH) : 1;

  mhk_pkg::req_t                    req;
  logic                             req_ready;
  logic                             res_valid;
  mhk_pkg::res_t                    res;
  logic                             res_take;
  logic                             mem_we;
  logic [AW-1:0]                    mem_waddr;
  logic signed [mhk_pkg::KEY_W-1:0] mem_wdata;
  logic                             mem_re;
  logic [AW-1:0]                    mem_raddr;
  logic signed [mhk_pkg::KEY_W-1:0] mem_rdata;

  logic                             out_valid_r;
  mhk_pkg::res_t                    out_res_r;

  assign req.operation = mhk_pkg::op_t'(in_operation);
  assign req.slot      = in_slot;
  assign req.key_value = in_key_value;
  assign in_stall      = !req_ready;

  mhk_sift #(
    .HEAP_DEPTH (HEAP_DEPTH),
    .AW         (AW)
  ) u_sift (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (in_valid),
    .req       (req),
    .req_ready (req_ready),
    .res_valid (res_valid),
    .res       (res),
    .res_take  (res_take),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  mhk_store #(
    .DEPTH (HEAP_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // The output register can take a new result whenever it is empty or being drained.
  assign res_take = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take && res_valid) begin
      out_res_r <= res;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_res_r.status;
  assign out_read_key   = out_res_r.read_key;
  assign out_heap_count = out_res_r.heap_count;
  assign out_top_key    = out_res_r.top_key;

endmodule

`default_nettype wire
